// ----- sv/c8x_pkg.sv -----
// Shared types and operation codes for the CHIP-8 execute unit.
`default_nettype none
package c8x_pkg;

    typedef struct packed {
        logic [5:0]  kind;
        logic [3:0]  reg_x;
        logic [3:0]  reg_y;
        logic [3:0]  rows;
        logic [7:0]  imm_byte;
        logic [11:0] imm_addr;
        logic [15:0] keys_now;
        logic [15:0] keys_before;
        logic [7:0]  random_byte;
        logic [11:0] host_address;
        logic [7:0]  host_data;
    } t_in_word;

    typedef struct packed {
        logic [15:0] program_counter;
        logic [15:0] index_value;
        logic [7:0]  flag_value;
        logic        reg_written;
        logic [3:0]  written_index;
        logic [7:0]  written_value;
        logic        waiting_key;
        logic        sound_active;
        logic [7:0]  read_data;
        logic        stack_fault;
    } t_out_word;

    localparam logic [5:0] K_CLS  = 6'd0,  K_RET  = 6'd1,  K_JP   = 6'd2,  K_CALL = 6'd3;
    localparam logic [5:0] K_SEI  = 6'd4,  K_SNEI = 6'd5,  K_SER  = 6'd6,  K_LDI  = 6'd7;
    localparam logic [5:0] K_ADDI = 6'd8,  K_MOV  = 6'd9,  K_OR   = 6'd10, K_AND  = 6'd11;
    localparam logic [5:0] K_XOR  = 6'd12, K_ADD  = 6'd13, K_SUB  = 6'd14, K_SHR  = 6'd15;
    localparam logic [5:0] K_SUBN = 6'd16, K_SHL  = 6'd17, K_SNER = 6'd18, K_LDIX = 6'd19;
    localparam logic [5:0] K_JPV0 = 6'd20, K_RND  = 6'd21, K_DRW  = 6'd22, K_SKP  = 6'd23;
    localparam logic [5:0] K_SKNP = 6'd24, K_GDT  = 6'd25, K_KEY  = 6'd26, K_SDT  = 6'd27;
    localparam logic [5:0] K_SST  = 6'd28, K_ADDX = 6'd29, K_FONT = 6'd30, K_BCD  = 6'd31;
    localparam logic [5:0] K_STM  = 6'd32, K_LDM  = 6'd33, K_TICK = 6'd34, K_HWR  = 6'd35;
    localparam logic [5:0] K_HRD  = 6'd36, K_SRD  = 6'd37;

    // controller to datapath commands
    typedef enum logic [3:0] {
        C_NONE, C_START, C_CLR, C_MRD, C_MWR, C_DRAW, C_LDREG, C_SCR, C_FIN
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] step;
    } t_cmd;

    typedef struct packed {
        logic [3:0] last_reg;
        logic [4:0] draw_rows;
    } t_sts;

endpackage
`default_nettype wire

// ----- sv/c8x_ctrl.sv -----
// Sequencer for multi-cycle operations of the execute unit.
`default_nettype none
module c8x_ctrl #(
    parameter int PIX = 2048
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire c8x_pkg::t_in_word i_in,
    input  wire c8x_pkg::t_sts  i_sts,
    output c8x_pkg::t_cmd       o_cmd,
    input  wire logic           i_out_busy
);
    import c8x_pkg::*;

    localparam int CW = $clog2(PIX / 8 + 1);

    typedef enum logic [2:0] {S_IDLE, S_CLR, S_MEM, S_DRAW, S_WAIT, S_FIN} t_state;

    t_state     r_state;
    logic [5:0] r_kind;
    logic [CW-1:0] r_cnt;
    logic [1:0] r_ph;

    assign o_in_ready = (r_state == S_IDLE) && !i_out_busy;

    always_comb begin
        o_cmd.op   = C_NONE;
        o_cmd.step = 8'(r_cnt);
        unique case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) o_cmd.op = C_START;
            S_CLR:  o_cmd.op = C_CLR;
            S_MEM: begin
                priority if (r_kind == K_BCD || r_kind == K_STM || r_kind == K_HWR)
                    o_cmd.op = C_MWR;
                else if (r_ph == 2'd0) o_cmd.op = C_MRD;
                else if (r_kind == K_SRD) o_cmd.op = C_SCR;
                else o_cmd.op = C_LDREG;
            end
            S_DRAW: o_cmd.op = (r_ph == 2'd0) ? C_MRD : C_DRAW;
            S_WAIT: o_cmd.op = C_NONE;
            S_FIN:  o_cmd.op = C_FIN;
            default: o_cmd.op = C_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= '0;
            r_cnt   <= '0;
            r_ph    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid && o_in_ready) begin
                    r_kind <= i_in.kind;
                    r_cnt  <= '0;
                    r_ph   <= '0;
                    priority case (i_in.kind)
                        K_CLS: r_state <= S_CLR;
                        K_BCD, K_STM, K_LDM, K_HWR, K_HRD, K_SRD: r_state <= S_MEM;
                        K_DRW: r_state <= S_DRAW;
                        default: r_state <= S_WAIT;
                    endcase
                end
                // all frame valid bits drop at once
                S_CLR: r_state <= S_FIN;
                S_MEM: begin
                    priority if (r_kind == K_BCD || r_kind == K_STM || r_kind == K_HWR) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_kind == K_HWR || (r_kind == K_BCD && r_cnt == CW'(2)) ||
                            (r_kind == K_STM && r_cnt[3:0] == i_sts.last_reg))
                            r_state <= S_WAIT;
                    end else if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph  <= 2'd0;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_kind != K_LDM || r_cnt[3:0] == i_sts.last_reg)
                            r_state <= S_WAIT;
                    end
                end
                S_DRAW: begin
                    if (r_ph == 2'd0) begin
                        if (r_cnt >= CW'(i_sts.draw_rows)) r_state <= S_WAIT;
                        else r_ph <= 2'd1;
                    end else begin
                        r_ph  <= 2'd0;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WAIT: r_state <= S_FIN;
                S_FIN:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/c8x_dp.sv -----
// Register file, memory, frame store and result formation.
`default_nettype none
module c8x_dp #(
    parameter int SW = 64,
    parameter int SH = 32,
    parameter int SD = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire c8x_pkg::t_in_word i_in,
    input  wire c8x_pkg::t_cmd     i_cmd,
    output c8x_pkg::t_sts          o_sts,
    output c8x_pkg::t_out_word     o_res,
    output logic                   o_res_load
);
    import c8x_pkg::*;

    localparam int PIX = SW * SH;
    localparam int RB  = PIX / 8;          // frame stored as rows of bytes
    localparam int RBW = $clog2(RB);
    localparam int BPR = SW / 8;
    localparam int XW  = $clog2(SW);
    localparam int YW  = $clog2(SH);
    localparam int SPW = $clog2(SD + 1);

    logic [7:0]  r_v [16];
    logic [15:0] r_i, r_pc, r_stk [16];
    logic [SPW-1:0] r_sp;
    logic [7:0]  r_dt, r_st;
    logic [7:0]  r_mem [4096];
    logic [7:0]  r_fb [RB];
    logic [RB-1:0] r_fbv;                  // frame byte valid; invalid reads as zero
    t_in_word    r_w;
    logic [7:0]  r_md, r_fd0, r_fd1, r_rd;
    logic [RBW-1:0] r_fa;
    logic        r_hit, r_wr, r_wait, r_flt;
    logic [3:0]  r_wi;

    logic [7:0] vx, vy, vf;
    logic [4:0] rows;
    logic [XW-1:0] xp;
    logic [YW-1:0] yp;
    assign vx = r_v[r_w.reg_x];
    assign vy = r_v[r_w.reg_y];
    assign vf = r_v[15];
    assign xp = XW'(vx % SW);
    assign yp = YW'(vy % SH);
    always_comb begin
        logic [6:0] lim;
        lim  = 7'(SH) - 7'(yp);
        rows = (7'(r_w.rows) < lim) ? 5'(r_w.rows) : 5'(lim);
    end
    assign o_sts.last_reg  = r_w.reg_x;
    assign o_sts.draw_rows = rows;

    // BCD digit for a step
    function automatic logic [7:0] bcd(input logic [7:0] v, input logic [1:0] s);
        logic [7:0] h, t, d;
        h = (v >= 8'd200) ? 8'd2 : (v >= 8'd100) ? 8'd1 : 8'd0;
        t = v - h * 8'd100;
        d = (t >= 8'd90) ? 8'd9 : (t >= 8'd80) ? 8'd8 : (t >= 8'd70) ? 8'd7 :
            (t >= 8'd60) ? 8'd6 : (t >= 8'd50) ? 8'd5 : (t >= 8'd40) ? 8'd4 :
            (t >= 8'd30) ? 8'd3 : (t >= 8'd20) ? 8'd2 : (t >= 8'd10) ? 8'd1 : 8'd0;
        unique case (s)
            2'd0: bcd = h;
            2'd1: bcd = d;
            default: bcd = t - d * 8'd10;
        endcase
    endfunction

    // memory address and data for the current step
    logic [11:0] maddr;
    logic [7:0]  mdata;
    always_comb begin
        maddr = r_i[11:0] + 12'(i_cmd.step);
        mdata = r_v[i_cmd.step[3:0]];
        if (r_w.kind == K_HWR || r_w.kind == K_HRD) maddr = r_w.host_address;
        if (r_w.kind == K_HWR) mdata = r_w.host_data;
        if (r_w.kind == K_BCD) mdata = bcd(vx, i_cmd.step[1:0]);
    end

    // sprite row placement: the one or two frame bytes straddled by an 8-pixel row
    logic [RBW-1:0] fa0, fa1;
    logic [2:0]  sh;
    logic        has1;
    logic [15:0] spr;
    always_comb begin
        logic [YW-1:0] yy;
        yy   = yp + YW'(i_cmd.step);
        fa0  = RBW'(yy) * RBW'(BPR) + RBW'(xp >> 3);
        fa1  = fa0 + 1'b1;
        sh   = xp[2:0];
        has1 = (xp >> 3) != XW'(BPR - 1);
        spr  = {r_md, 8'h00} >> sh;
        if (!has1) spr[7:0] = 8'h00;
    end
    logic [RBW-1:0] fsa;
    assign fsa = RBW'(r_w.host_address);

    // result word is taken the cycle after finish
    always_ff @(posedge i_clk) begin
        o_res_load <= i_rst_n && (i_cmd.op == C_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            r_i <= '0; r_pc <= 16'd512; r_sp <= '0; r_dt <= '0; r_st <= '0;
            r_fbv <= '0;
        end else begin
            unique case (i_cmd.op)
                C_START: begin
                    r_w <= i_in; r_hit <= 1'b0; r_rd <= '0;
                    r_wr <= 1'b0; r_wi <= '0; r_wait <= 1'b0; r_flt <= 1'b0;
                end
                C_CLR: r_fbv <= '0;
                C_MRD: begin
                    r_md <= r_mem[maddr];
                    r_fa <= fa0;
                    r_fd0 <= r_fbv[fa0] ? r_fb[fa0] : 8'h00;
                    r_fd1 <= r_fbv[fa1] ? r_fb[fa1] : 8'h00;
                end
                C_MWR: r_mem[maddr] <= mdata;
                C_LDREG: begin
                    if (r_w.kind == K_LDM) r_v[i_cmd.step[3:0]] <= r_md;
                    else r_rd <= r_md;
                end
                C_SCR: r_rd <= (r_w.host_address < 12'(RB) && r_fbv[fsa]) ? r_fb[fsa] : 8'h00;
                C_DRAW: begin
                    r_fb[r_fa] <= r_fd0 ^ spr[15:8];
                    r_fbv[r_fa] <= 1'b1;
                    if (((r_fd0 & spr[15:8]) != 0) || (has1 && (r_fd1 & spr[7:0]) != 0))
                        r_hit <= 1'b1;
                    if (has1) begin
                        r_fb[r_fa + 1'b1] <= r_fd1 ^ spr[7:0];
                        r_fbv[r_fa + 1'b1] <= 1'b1;
                    end
                end
                C_FIN: begin
                    logic [15:0] pc;
                    logic [7:0]  nv;
                    logic        wr, f, wf;
                    int          k;
                    pc = (r_w.kind <= K_LDM) ? r_pc + 16'd2 : r_pc;
                    wr = 1'b0; wf = 1'b0; f = 1'b0; nv = '0;
                    unique case (r_w.kind)
                        K_RET: if (r_sp == 0) r_flt <= 1'b1;
                               else begin pc = r_stk[4'(r_sp - 1'b1)]; r_sp <= r_sp - 1'b1; end
                        K_JP: pc = {4'h0, r_w.imm_addr};
                        K_CALL: if (r_sp >= SPW'(SD)) r_flt <= 1'b1;
                                else begin
                                    r_stk[4'(r_sp)] <= pc; r_sp <= r_sp + 1'b1;
                                    pc = {4'h0, r_w.imm_addr};
                                end
                        K_SEI:  if (vx == r_w.imm_byte) pc = pc + 16'd2;
                        K_SNEI: if (vx != r_w.imm_byte) pc = pc + 16'd2;
                        K_SER:  if (vx == vy) pc = pc + 16'd2;
                        K_SNER: if (vx != vy) pc = pc + 16'd2;
                        K_LDI:  begin wr = 1'b1; nv = r_w.imm_byte; end
                        K_ADDI: begin wr = 1'b1; nv = vx + r_w.imm_byte; end
                        K_MOV:  begin wr = 1'b1; nv = vy; end
                        K_OR:   begin wr = 1'b1; nv = vx | vy; end
                        K_AND:  begin wr = 1'b1; nv = vx & vy; end
                        K_XOR:  begin wr = 1'b1; nv = vx ^ vy; end
                        K_ADD:  begin wr = 1'b1; wf = 1'b1; {f, nv} = {1'b0, vx} + {1'b0, vy}; end
                        K_SUB:  begin wr = 1'b1; wf = 1'b1; f = vx >= vy; nv = vx - vy; end
                        K_SHR:  begin wr = 1'b1; wf = 1'b1; f = vx[0]; nv = vx >> 1; end
                        K_SUBN: begin wr = 1'b1; wf = 1'b1; f = vy >= vx; nv = vy - vx; end
                        K_SHL:  begin wr = 1'b1; wf = 1'b1; f = vx[7]; nv = vx << 1; end
                        K_LDIX: r_i <= {4'h0, r_w.imm_addr};
                        K_JPV0: pc = {4'h0, r_w.imm_addr} + {8'h00, r_v[0]};
                        K_RND:  begin wr = 1'b1; nv = r_w.random_byte & r_w.imm_byte; end
                        K_SKP:  if (r_w.keys_now[vx[3:0]]) pc = pc + 16'd2;
                        K_SKNP: if (!r_w.keys_now[vx[3:0]]) pc = pc + 16'd2;
                        K_GDT:  begin wr = 1'b1; nv = r_dt; end
                        K_KEY: begin
                            for (k = 0; k < 16; k++)
                                if (r_w.keys_before[k] && !r_w.keys_now[k]) begin
                                    wr = 1'b1; nv = 8'(k);
                                end
                            if (!wr) begin pc = pc - 16'd2; r_wait <= 1'b1; end
                        end
                        K_SDT:  r_dt <= vx;
                        K_SST:  r_st <= vx;
                        K_ADDX: r_i <= r_i + {8'h00, vx};
                        K_FONT: r_i <= {12'h000, vx[3:0]} * 16'd5;
                        K_TICK: begin
                            if (r_dt != 0) r_dt <= r_dt - 1'b1;
                            if (r_st != 0) r_st <= r_st - 1'b1;
                        end
                        default: ;
                    endcase
                    r_pc <= pc;
                    if (r_w.kind == K_DRW) begin
                        r_v[15] <= {7'h00, r_hit}; r_wr <= 1'b1; r_wi <= 4'hF;
                    end else if (wr) begin
                        // flag wins when VF is also the destination
                        r_v[r_w.reg_x] <= (wf && r_w.reg_x == 4'hF) ? {7'h00, f} : nv;
                        r_wr <= 1'b1; r_wi <= r_w.reg_x;
                        if (wf && r_w.reg_x != 4'hF) r_v[15] <= {7'h00, f};
                    end
                end
                default: ;
            endcase
        end
    end

    // result is read the cycle after finish, from updated state
    always_comb begin
        o_res.program_counter = r_pc;
        o_res.index_value     = r_i;
        o_res.flag_value      = vf;
        o_res.reg_written     = r_wr;
        o_res.written_index   = r_wr ? r_wi : 4'h0;
        o_res.written_value   = r_wr ? r_v[r_wi] : 8'h00;
        o_res.waiting_key     = r_wait;
        o_res.sound_active    = r_st != 0;
        o_res.read_data       = r_rd;
        o_res.stack_fault     = r_flt;
    end
endmodule
`default_nettype wire

// ----- sv/chip8_execute_unit.sv -----
// Top level of the CHIP-8 execute unit: controller, datapath, output register.
//
// Usage: one decoded instruction word enters on i_in_valid/o_in_ready; one
// result word leaves on o_out_valid/i_out_ready, carrying pc, index, VF,
// the written register and host read data after the instruction.
// Sequencing: after accept, a simple instruction passes the wait and finish
// states. Sprite draw adds a memory read and a frame write per drawn row (at
// most 15 rows), block load a read and a register load per register, block
// store a memory write per register, BCD three digit writes, host memory
// write one memory write, host memory and frame reads a read and a result step.
// Clear screen drops every frame valid bit at once and costs no more than a
// simple instruction; the single-port 4096-byte memory and the frame byte
// store set the per-row cost. One instruction is in flight at a time; the
// next is accepted the cycle after the result word is taken.
// Reset: registers zero, pc 512, stack empty, timers zero, frame dark.
// Memory contents are undefined until written.
// When the receiver stalls, the result holds and no input is taken.
`default_nettype none
module chip8_execute_unit #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int STACK_DEPTH   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire c8x_pkg::t_in_word  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output c8x_pkg::t_out_word      o_out
);
    import c8x_pkg::*;

    t_cmd      cmd;
    t_sts      sts;
    t_out_word res;
    logic      res_load, r_busy;

    c8x_ctrl #(.PIX(SCREEN_WIDTH * SCREEN_HEIGHT)) u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in,
        .i_sts(sts), .o_cmd(cmd), .i_out_busy(r_busy)
    );

    c8x_dp #(.SW(SCREEN_WIDTH), .SH(SCREEN_HEIGHT), .SD(STACK_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_in, .i_cmd(cmd), .o_sts(sts),
        .o_res(res), .o_res_load(res_load)
    );

    // busy from accept until the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            if (res_load) begin
                o_out_valid <= 1'b1;
                o_out       <= res;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
                r_busy      <= 1'b0;
            end
            if (i_in_valid && o_in_ready) r_busy <= 1'b1;
        end
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready) else $error("second accept");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("ready with pending word");
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> r_busy) else $error("result without item");
endmodule
`default_nettype wire
